// File: hdl/prefixed_rotate_shift_bit_unit_defines.svh
// Assertion macros for the prefixed rotate/shift/bit unit.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef PREFIXED_ROTATE_SHIFT_BIT_UNIT_DEFINES_SVH
`define PREFIXED_ROTATE_SHIFT_BIT_UNIT_DEFINES_SVH

// Check a condition on every edge out of reset
`define PRSBU_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check a consequence on the same edge as its trigger
`define PRSBU_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence on the edge after its trigger
`define PRSBU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/prsbu_pkg.sv
// Shared types and constants for the prefixed rotate/shift/bit unit.
// No dependencies.
package prsbu_pkg;

   // Request word: second opcode byte, operand and incoming flags
   typedef struct packed {
      logic [7:0] op;
      logic [7:0] operand_value;
      logic [3:0] flags_in;
   } req_type;

   // Response word
   typedef struct packed {
      logic [7:0] result_value;
      logic       write_back;
      logic [2:0] target_index;
      logic [3:0] flags_out;
      logic [4:0] cycle_count;
   } rsp_type;

   // Opcode group, bits 7..6
   typedef enum logic [1:0] {
      GRP_ROT = 2'd0,
      GRP_BIT = 2'd1,
      GRP_RES = 2'd2,
      GRP_SET = 2'd3
   } group_type;

   // Rotate/shift selector, bits 5..3 in the rotate group
   typedef enum logic [2:0] {
      ROT_RLC  = 3'd0,
      ROT_RRC  = 3'd1,
      ROT_RL   = 3'd2,
      ROT_RR   = 3'd3,
      ROT_SLA  = 3'd4,
      ROT_SRA  = 3'd5,
      ROT_SWAP = 3'd6,
      ROT_SRL  = 3'd7
   } rot_op_type;

   // Flag bit positions
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   // Target code for the memory byte at HL
   localparam logic [2:0] TGT_MEM = 3'd6;

   // Machine cycle counts
   localparam logic [4:0] CYC_REG = 5'd8;
   localparam logic [4:0] CYC_MEM = 5'd16;

endpackage

// File: hdl/prsbu_exec.sv
// Combinational execute stage: decodes one prefixed opcode and forms the response word.
// Depends on prsbu_pkg.
module prsbu_exec (
   input  prsbu_pkg::req_type req,
   output prsbu_pkg::rsp_type rsp
);

   prsbu_pkg::group_type  group;
   prsbu_pkg::rot_op_type rot_op;
   logic [2:0]            bit_idx;
   logic [7:0]            mask;
   logic [7:0]            v;
   logic                  cin;
   logic [7:0]            rot_res;
   logic                  rot_c;

   // Split the opcode fields
   assign group   = prsbu_pkg::group_type'(req.op[7:6]);
   assign bit_idx = req.op[5:3];
   assign rot_op  = prsbu_pkg::rot_op_type'(req.op[5:3]);
   assign mask    = 8'b0000_0001 << bit_idx;
   assign v       = req.operand_value;
   assign cin     = req.flags_in[prsbu_pkg::FLAG_C];

   // Rotate, shift and swap
   always_comb begin
      case (rot_op)
         prsbu_pkg::ROT_RLC: begin
            rot_c   = v[7];
            rot_res = {v[6:0], v[7]};
         end
         prsbu_pkg::ROT_RRC: begin
            rot_c   = v[0];
            rot_res = {v[0], v[7:1]};
         end
         prsbu_pkg::ROT_RL: begin
            rot_c   = v[7];
            rot_res = {v[6:0], cin};
         end
         prsbu_pkg::ROT_RR: begin
            rot_c   = v[0];
            rot_res = {cin, v[7:1]};
         end
         prsbu_pkg::ROT_SLA: begin
            rot_c   = v[7];
            rot_res = {v[6:0], 1'b0};
         end
         prsbu_pkg::ROT_SRA: begin
            rot_c   = v[0];
            rot_res = {v[7], v[7:1]};
         end
         prsbu_pkg::ROT_SWAP: begin
            rot_c   = 1'b0;
            rot_res = {v[3:0], v[7:4]};
         end
         default: begin
            rot_c   = v[0];
            rot_res = {1'b0, v[7:1]};
         end
      endcase
   end

   // Select result and flags by group; target and timing follow the low opcode bits
   always_comb begin
      rsp.result_value = v;
      rsp.write_back   = 1'b1;
      rsp.flags_out    = req.flags_in;
      rsp.target_index = req.op[2:0];
      rsp.cycle_count  = (req.op[2:0] == prsbu_pkg::TGT_MEM) ?
                         prsbu_pkg::CYC_MEM : prsbu_pkg::CYC_REG;
      case (group)
         prsbu_pkg::GRP_ROT: begin
            rsp.result_value = rot_res;
            rsp.flags_out    = 4'b0000;
            rsp.flags_out[prsbu_pkg::FLAG_Z] = (rot_res == 8'h00);
            rsp.flags_out[prsbu_pkg::FLAG_C] = rot_c;
         end
         prsbu_pkg::GRP_BIT: begin
            rsp.write_back = 1'b0;
            rsp.flags_out  = 4'b0000;
            rsp.flags_out[prsbu_pkg::FLAG_Z] = ((v & mask) == 8'h00);
            rsp.flags_out[prsbu_pkg::FLAG_H] = 1'b1;
            rsp.flags_out[prsbu_pkg::FLAG_C] = cin;
         end
         prsbu_pkg::GRP_RES: begin
            rsp.result_value = v & ~mask;
         end
         default: begin
            rsp.result_value = v | mask;
         end
      endcase
   end

endmodule

// File: hdl/prefixed_rotate_shift_bit_unit.sv
// Prefixed rotate/shift/bit unit: input register, execute logic, result register.
// Path: a word accepted into the input register passes the execute logic and is
// captured in the result register, from which it is offered on rsp.
// Throughput: one word per cycle while rsp_stall is low; while the result register
// holds a stalled word, the input register takes one more word, then stalls requests.
// Reset: synchronous, active high; clears both stage valid bits.
// Depends on prsbu_pkg, prsbu_exec and the defines header.
`include "prefixed_rotate_shift_bit_unit_defines.svh"

module prefixed_rotate_shift_bit_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  prsbu_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output prsbu_pkg::rsp_type rsp_data
);

   logic               in_vld_ff;
   logic               in_vld_in;
   prsbu_pkg::req_type in_ff;
   logic               out_vld_ff;
   logic               out_vld_in;
   prsbu_pkg::rsp_type out_ff;
   prsbu_pkg::rsp_type exec_rsp;
   logic               out_take;
   logic               in_take;

   // Result register advances when empty or being drained
   assign out_take  = !out_vld_ff || !rsp_stall;
   // Input register loads when empty or when its word moves on
   assign in_take   = !in_vld_ff || out_take;
   assign req_stall = !in_take;

   assign in_vld_in  = req_valid ? 1'b1 : (in_vld_ff && !out_take);
   assign out_vld_in = out_take ? in_vld_ff : out_vld_ff;

   // Hold the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (in_take) begin
            in_vld_ff <= in_vld_in;
         end
         out_vld_ff <= out_vld_in;
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (in_take && req_valid) begin
         in_ff <= req_data;
      end
   end

   prsbu_exec u_exec (
      .req (in_ff),
      .rsp (exec_rsp)
   );

   // Capture the response word
   always_ff @(posedge clock) begin
      if (out_take && in_vld_ff) begin
         out_ff <= exec_rsp;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // A result appears only after a word sat in the input register
   `PRSBU_ASSERT_IMPL(a_out_from_in, $rose(out_vld_ff), $past(in_vld_ff), "result without input word")
   // A word in the input register moves on when the output side takes
   `PRSBU_ASSERT_NEXT(a_in_moves, in_vld_ff && out_take, out_vld_ff, "input word lost")
   // Cycle count matches the memory target
   `PRSBU_ASSERT_IMPL(a_cycles, rsp_valid, (rsp_data.cycle_count == prsbu_pkg::CYC_MEM) == (rsp_data.target_index == prsbu_pkg::TGT_MEM), "bad cycle count")
   // A result without write-back must carry H set, as a bit test does
   `PRSBU_ASSERT_NOW(a_bit_flags, !rsp_valid || rsp_data.write_back || rsp_data.flags_out[prsbu_pkg::FLAG_H], "bit test without H")

endmodule

// File: tb/sv/prsbu_result_checker.sv
// Checker for the prefixed rotate/shift/bit unit: watches both channels,
// predicts each result word and compares it field by field in order.
// Depends on prsbu_pkg.
module prsbu_result_checker
   import prsbu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   output int unsigned fail_count,
   output int unsigned pending_count
);

   rsp_type     expected_words[$];
   int unsigned mismatches = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Compute the result word that one prefixed instruction must produce
   function automatic rsp_type predict_cb_result(input req_type w);
      rsp_type    r;
      group_type  grp;
      logic [2:0] sel;
      logic [7:0] v;
      logic [7:0] mask;
      logic       carry_in;
      logic       carry_out;
      grp      = group_type'(w.op[7:6]);
      sel      = w.op[5:3];
      v        = w.operand_value;
      mask     = 8'h01 << sel;
      carry_in = w.flags_in[FLAG_C];
      carry_out = 1'b0;

      r.result_value = v;
      r.write_back   = 1'b1;
      r.target_index = w.op[2:0];
      r.flags_out    = w.flags_in;
      r.cycle_count  = (w.op[2:0] == TGT_MEM) ? CYC_MEM : CYC_REG;

      case (grp)
         GRP_ROT: begin
            case (rot_op_type'(sel))
               ROT_RLC: begin
                  carry_out = v[7];
                  r.result_value = {v[6:0], v[7]};
               end
               ROT_RRC: begin
                  carry_out = v[0];
                  r.result_value = {v[0], v[7:1]};
               end
               ROT_RL: begin
                  carry_out = v[7];
                  r.result_value = {v[6:0], carry_in};
               end
               ROT_RR: begin
                  carry_out = v[0];
                  r.result_value = {carry_in, v[7:1]};
               end
               ROT_SLA: begin
                  carry_out = v[7];
                  r.result_value = {v[6:0], 1'b0};
               end
               ROT_SRA: begin
                  carry_out = v[0];
                  r.result_value = {v[7], v[7:1]};
               end
               ROT_SWAP: begin
                  carry_out = 1'b0;
                  r.result_value = {v[3:0], v[7:4]};
               end
               default: begin
                  carry_out = v[0];
                  r.result_value = {1'b0, v[7:1]};
               end
            endcase
            r.flags_out         = '0;
            r.flags_out[FLAG_Z] = (r.result_value == 8'h00);
            r.flags_out[FLAG_C] = carry_out;
         end
         GRP_BIT: begin
            r.write_back        = 1'b0;
            r.flags_out         = '0;
            r.flags_out[FLAG_Z] = ((v & mask) == 8'h00);
            r.flags_out[FLAG_H] = 1'b1;
            r.flags_out[FLAG_C] = carry_in;
         end
         GRP_RES: begin
            r.result_value = v & ~mask;
         end
         default: begin
            r.result_value = v | mask;
         end
      endcase
      return r;
   endfunction

   // Report one field that differs from its prediction
   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                  act_val);
         mismatches++;
      end
   endtask

   // Pop and compare accepted results, then queue predictions for accepted words
   always @(posedge clock) begin
      rsp_type exp_word;
      if (reset) begin
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %h", $time,
                        rsp_data);
               mismatches++;
            end else begin
               exp_word = expected_words.pop_front();
               check_field("result_value", exp_word.result_value, rsp_data.result_value);
               check_field("write_back", exp_word.write_back, rsp_data.write_back);
               check_field("target_index", exp_word.target_index, rsp_data.target_index);
               check_field("flags_out", exp_word.flags_out, rsp_data.flags_out);
               check_field("cycle_count", exp_word.cycle_count, rsp_data.cycle_count);
            end
         end
         if (req_valid && !req_stall) begin
            expected_words.push_back(predict_cb_result(req_data));
         end
      end
      pending_count <= expected_words.size();
      fail_count    <= mismatches;
   end

endmodule

// File: tb/sv/tb_top.sv
// Top of the testbench for the prefixed rotate/shift/bit unit: clock, reset,
// instruction stimulus, result-side stalls and the verdict.
// Depends on prsbu_pkg, prsbu_result_checker and the unit itself.
module tb_top;
   import prsbu_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_WORDS = 850;
   localparam int unsigned DRAIN_CYCLES = 10;

   // Register targets; the memory target comes from the package
   localparam logic [2:0] TGT_B = 3'd0;
   localparam logic [2:0] TGT_C = 3'd1;
   localparam logic [2:0] TGT_D = 3'd2;
   localparam logic [2:0] TGT_E = 3'd3;
   localparam logic [2:0] TGT_H = 3'd4;
   localparam logic [2:0] TGT_L = 3'd5;
   localparam logic [2:0] TGT_A = 3'd7;

   localparam logic [3:0] FLAGS_NONE = 4'h0;
   localparam logic [3:0] FLAGS_ALL  = 4'hF;
   localparam logic [3:0] FLAGS_C    = 4'h1;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned send_hold_max = 0;
   int unsigned rsp_hold_max  = 0;
   int unsigned cycles        = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   prefixed_rotate_shift_bit_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   prsbu_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Offer one instruction word after a random gap and hold it until taken
   task automatic send_word(input req_type w);
      int unsigned gap;
      gap = $urandom_range(0, send_hold_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_cb(input group_type grp, input logic [2:0] sel,
                          input logic [2:0] tgt, input logic [7:0] value,
                          input logic [3:0] flags);
      req_type w;
      w.op            = {grp, sel, tgt};
      w.operand_value = value;
      w.flags_in      = flags;
      send_word(w);
   endtask

   // Drop valid and hold until every predicted result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Result side: stall for a random number of cycles before each word
   initial begin : result_side
      int unsigned hold;
      forever begin
         hold = $urandom_range(0, rsp_hold_max);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Abort a hung run
   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      req_type w;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every rotate/shift, carry in and out, zero results, bit ops
      send_hold_max = 3;
      rsp_hold_max  = 3;
      send_cb(GRP_ROT, ROT_RLC, TGT_B, 8'h80, FLAGS_NONE);
      send_cb(GRP_ROT, ROT_RRC, TGT_C, 8'h01, FLAGS_NONE);
      send_cb(GRP_ROT, ROT_RL, TGT_D, 8'h80, FLAGS_NONE);
      send_cb(GRP_ROT, ROT_RL, TGT_E, 8'h00, FLAGS_C);
      send_cb(GRP_ROT, ROT_RR, TGT_H, 8'h01, FLAGS_C);
      send_cb(GRP_ROT, ROT_RR, TGT_L, 8'h00, FLAGS_NONE);
      send_cb(GRP_ROT, ROT_SLA, TGT_L, 8'hFF, FLAGS_ALL);
      send_cb(GRP_ROT, ROT_SLA, TGT_A, 8'h80, FLAGS_NONE);
      send_cb(GRP_ROT, ROT_SRA, TGT_MEM, 8'h80, FLAGS_NONE);
      send_cb(GRP_ROT, ROT_SRA, TGT_B, 8'h01, FLAGS_ALL);
      send_cb(GRP_ROT, ROT_SWAP, TGT_A, 8'h00, FLAGS_C);
      send_cb(GRP_ROT, ROT_SWAP, TGT_MEM, 8'hF0, FLAGS_ALL);
      send_cb(GRP_ROT, ROT_SRL, TGT_C, 8'h01, FLAGS_NONE);
      send_cb(GRP_ROT, ROT_SRL, TGT_D, 8'hFF, FLAGS_C);
      send_cb(GRP_BIT, 3'd7, TGT_A, 8'h7F, FLAGS_NONE);
      send_cb(GRP_BIT, 3'd0, TGT_B, 8'h01, FLAGS_C);
      send_cb(GRP_BIT, 3'd3, TGT_MEM, 8'hFF, FLAGS_ALL);
      send_cb(GRP_BIT, 3'd5, TGT_E, 8'h00, FLAGS_ALL);
      send_cb(GRP_RES, 3'd0, TGT_MEM, 8'hFF, FLAGS_NONE);
      send_cb(GRP_RES, 3'd7, TGT_A, 8'h80, FLAGS_ALL);
      send_cb(GRP_SET, 3'd7, TGT_B, 8'h00, FLAGS_NONE);
      send_cb(GRP_SET, 3'd0, TGT_MEM, 8'hFF, FLAGS_ALL);
      send_cb(GRP_SET, 3'd7, TGT_A, 8'hFF, FLAGS_ALL);
      send_cb(GRP_ROT, ROT_RLC, TGT_B, 8'h00, FLAGS_NONE);
      wait_drained();

      // Random: blocks of words with fresh idling on each side
      for (int unsigned k = 0; k < RANDOM_WORDS; k++) begin
         if (k % 50 == 0) begin
            send_hold_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            rsp_hold_max  = ($urandom_range(0, 2) == 0) ? 0 : 10;
            if (k % 200 == 100) begin
               send_hold_max = 0;
               rsp_hold_max  = 0;
            end
         end
         if (k == RANDOM_WORDS / 2) begin
            wait_drained();
         end
         w.op            = 8'($urandom_range(0, 255));
         w.operand_value = 8'($urandom_range(0, 255));
         w.flags_in      = 4'($urandom_range(0, 15));
         send_word(w);
      end

      // Drain, allow for late strays, then decide
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/prsbu_pkg.sv
hdl/prsbu_exec.sv
hdl/prefixed_rotate_shift_bit_unit.sv
tb/sv/prsbu_result_checker.sv
tb/sv/tb_top.sv
